// ----- src/decimal_complement_add_shift_top_assert.svh -----
// assertion macros for the decimal add and shift unit
`ifndef DECIMAL_COMPLEMENT_ADD_SHIFT_TOP_ASSERT_SVH
`define DECIMAL_COMPLEMENT_ADD_SHIFT_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define DCAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// signal holds its value in the cycle after the condition
`define DCAS_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- src/dcas_pkg.sv -----
// ---------------------------------------------------------------------------
// dcas_pkg
// Shared constants, types and the digit split function for the decimal
// ten's complement add and shift unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcas_pkg;

  localparam int DIGITS  = 15;
  localparam int FIELD_W = 60;
  localparam int DIG_W   = 4 * DIGITS;
  localparam int USED_W  = (DIG_W < FIELD_W) ? DIG_W : FIELD_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_MUL10 = 2'd2,
    OP_DIV10 = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              a_neg;
    logic              b_neg;
    logic [DIG_W-1:0]  a_orig;
    logic [DIG_W-1:0]  a_rem;
    logic [DIG_W-1:0]  b_rem;
    logic [DIG_W-1:0]  r1;
    logic [DIG_W-1:0]  r2;
    logic signed [3:0] c1;
    logic signed [3:0] c2;
  } item_t;

  typedef struct packed {
    logic [3:0]        digit;
    logic signed [3:0] carry;
  } split_t;

  // digit and floor carry of a signed column sum in -40..39
  function automatic split_t dec_split(logic signed [6:0] t);
    logic [7:0] u;
    logic [2:0] q;
    logic [7:0] r;
    split_t     s;
    u = 8'(t) + 8'd40;
    q = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if (u >= 8'(10 * k)) q = q + 3'd1;
    end
    r = u - 8'(int'(q) * 10);
    s.digit = r[3:0];
    s.carry = $signed({1'b0, q}) - 4'sd4;
    return s;
  endfunction

endpackage

// ----- src/decimal_complement_add_shift_top.sv -----
// ---------------------------------------------------------------------------
// decimal_complement_add_shift_top
// Signed packed BCD add, subtract, multiply by ten and divide by ten.
// ---------------------------------------------------------------------------
// One request per cycle enters and one result per cycle leaves while the
// output is not stalled. A request walks a row of DIGITS digit cells, one
// cell per cycle unless stalled, carrying the sum and its negation digit by
// digit, and the output register then takes sign, magnitude and overflow
// picked from the last cell. Empty cells close up while the output is stalled.
`timescale 1ns / 1ps

module decimal_complement_add_shift_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 operation,
  input  logic                       a_negative,
  input  logic [dcas_pkg::FIELD_W-1:0] a_digits,
  input  logic                       b_negative,
  input  logic [dcas_pkg::FIELD_W-1:0] b_digits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       result_negative,
  output logic [dcas_pkg::FIELD_W-1:0] result_digits,
  output logic                       overflow
);
  import dcas_pkg::*;

  item_t             head;
  item_t             stage [DIGITS];
  logic [DIGITS-1:0] stage_valid;
  logic [DIGITS:0]   ready;
  item_t             last;
  op_t               head_op;
  logic [DIG_W-1:0]  a_ext;
  logic [DIG_W-1:0]  b_ext;
  logic [DIG_W-1:0]  mul_dig;
  logic [DIG_W-1:0]  div_dig;
  logic [USED_W-1:0] sel_dig;
  logic              sel_neg;
  logic              sel_ovf;

  assign a_ext   = DIG_W'(a_digits[USED_W-1:0]);
  assign b_ext   = DIG_W'(b_digits[USED_W-1:0]);
  assign head_op = op_t'(operation);

  always_comb begin
    head.op     = head_op;
    head.a_neg  = a_negative;
    head.b_neg  = b_negative ^ (head_op == OP_SUB);
    head.a_orig = a_ext;
    head.a_rem  = a_ext;
    head.b_rem  = b_ext;
    head.r1     = '0;
    head.r2     = '0;
    head.c1     = 4'sd0;
    head.c2     = 4'sd0;
  end

  assign ready[DIGITS] = !out_valid || !out_stall;
  assign in_stall      = !ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    assign ready[k] = !stage_valid[k] || ready[k+1];
    if (k == 0) begin : g_first
      dcas_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_item   (head),
        .in_valid  (in_valid),
        .load      (ready[k]),
        .out_item  (stage[k]),
        .out_valid (stage_valid[k])
      );
    end else begin : g_next
      dcas_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_item   (stage[k-1]),
        .in_valid  (stage_valid[k-1]),
        .load      (ready[k]),
        .out_item  (stage[k]),
        .out_valid (stage_valid[k])
      );
    end
  end

  assign last    = stage[DIGITS-1];
  assign mul_dig = {last.a_orig[DIG_W-5:0], 4'd0};
  assign div_dig = {4'd0, last.a_orig[DIG_W-1:4]};

  always_comb begin
    sel_ovf = 1'b0;
    sel_neg = 1'b0;
    sel_dig = '0;
    case (last.op)
      OP_ADD, OP_SUB: begin
        if (!last.c1[3]) begin
          sel_ovf = (last.c1 != 4'sd0);
          if (!sel_ovf) sel_dig = last.r1[USED_W-1:0];
        end else begin
          sel_ovf = (last.c2 != 4'sd0);
          if (!sel_ovf) begin
            sel_dig = last.r2[USED_W-1:0];
            sel_neg = 1'b1;
          end
        end
      end
      OP_MUL10: begin
        if (last.a_orig[DIG_W-1 -: 4] != 4'd0) begin
          sel_ovf = 1'b1;
          sel_dig = last.a_orig[USED_W-1:0];
          sel_neg = last.a_neg;
        end else begin
          sel_dig = mul_dig[USED_W-1:0];
          sel_neg = last.a_neg && (sel_dig != '0);
        end
      end
      OP_DIV10: begin
        sel_dig = div_dig[USED_W-1:0];
        sel_neg = last.a_neg && (sel_dig != '0);
      end
      default: begin
        sel_dig = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready[DIGITS]) begin
      out_valid <= stage_valid[DIGITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[DIGITS]) begin
      result_negative <= sel_neg;
      result_digits   <= FIELD_W'(sel_dig);
      overflow        <= sel_ovf;
    end
  end

endmodule

// ----- src/dcas_cell.sv -----
// ---------------------------------------------------------------------------
// dcas_cell
// One digit cell: adds the low digits of both operands with signs into two
// complementary carry chains, shifts the digit into the result and registers
// the request for the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcas_cell (
  input  logic           clk,
  input  logic           rst,
  input  dcas_pkg::item_t in_item,
  input  logic           in_valid,
  input  logic           load,
  output dcas_pkg::item_t out_item,
  output logic           out_valid
);
  import dcas_pkg::*;

  logic [3:0]        da;
  logic [3:0]        db;
  logic signed [6:0] av;
  logic signed [6:0] bv;
  logic signed [6:0] t1;
  logic signed [6:0] t2;
  split_t            s1;
  split_t            s2;
  item_t             item_next;

  always_comb begin
    da = in_item.a_rem[3:0];
    db = in_item.b_rem[3:0];
    av = in_item.a_neg ? -$signed({3'b000, da}) : $signed({3'b000, da});
    bv = in_item.b_neg ? -$signed({3'b000, db}) : $signed({3'b000, db});
    t1 = av + bv + 7'(in_item.c1);
    t2 = -av - bv + 7'(in_item.c2);
    s1 = dec_split(t1);
    s2 = dec_split(t2);
    item_next       = in_item;
    item_next.a_rem = in_item.a_rem >> 4;
    item_next.b_rem = in_item.b_rem >> 4;
    item_next.r1    = {s1.digit, in_item.r1[DIG_W-1:4]};
    item_next.r2    = {s2.digit, in_item.r2[DIG_W-1:4]};
    item_next.c1    = s1.carry;
    item_next.c2    = s2.carry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- src/dcas_checker.sv -----
// ---------------------------------------------------------------------------
// dcas_checker
// Port level checks for the decimal add and shift unit, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_complement_add_shift_top_assert.svh"

module dcas_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   operation,
  input logic                         a_negative,
  input logic [dcas_pkg::FIELD_W-1:0] a_digits,
  input logic                         b_negative,
  input logic [dcas_pkg::FIELD_W-1:0] b_digits,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         result_negative,
  input logic [dcas_pkg::FIELD_W-1:0] result_digits,
  input logic                         overflow
);
  import dcas_pkg::*;

  logic [FIELD_W+1:0]   out_payload;
  logic [2*FIELD_W+3:0] in_payload;

  assign out_payload = {result_negative, overflow, result_digits};
  assign in_payload  = {operation, a_negative, a_digits, b_negative, b_digits};

  `DCAS_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "result dropped")
  `DCAS_ASSERT_HOLD(a_out_payload_hold, out_valid && out_stall, out_payload, "result changed")
  `DCAS_ASSERT_HOLD(a_in_payload_hold, in_valid && in_stall, in_payload, "request changed")
  `DCAS_ASSERT(a_zero_positive, out_valid && result_digits == '0 |-> !result_negative, "neg zero")
  `DCAS_ASSERT(a_reset_empty, $past(rst) |-> !out_valid && !in_stall, "not empty after reset")

endmodule

bind decimal_complement_add_shift_top dcas_checker u_dcas_checker (.*);
